// ----- rtl/mtfs_pkg.sv -----
// shared types, constants and helper functions for the min-tree floor search block
// no dependencies; imported by the node memory, the top level and the testbench
`default_nettype none

package mtfs_pkg;

    // tree geometry
    localparam int LEAVES    = 1024;
    localparam int LEAF_W    = 10;
    localparam int NODE_W    = 11;
    localparam int NODE_CNT  = 2 * LEAVES;
    localparam int KEY_W     = 64;
    localparam int SIZE_W    = 11;
    localparam int LVL_W     = 4;
    localparam int MAX_LVL   = 10;

    // stream widths
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 16;

    localparam logic [KEY_W-1:0] KEY_EMPTY = {KEY_W{1'b1}};

    // command codes carried on s_tuser
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_FIND = 1'b1;

    // node memory write request
    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        logic [KEY_W-1:0]  data;
    } mem_wr_t;

    // size register value kept between 1 and LEAVES
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(LEAVES)) begin
            r = SIZE_W'(LEAVES);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // smallest b with 2^b >= v, for v from 1 to LEAVES
    function automatic logic [LVL_W-1:0] levels_for_size(input logic [SIZE_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = LVL_W'(MAX_LVL);
        for (int b = MAX_LVL; b >= 0; b--) begin
            if (({1'b0, v} <= ((SIZE_W+1)'(1) << b))) begin
                r = LVL_W'(b);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mtfs_node_mem.sv -----
// node minimum store: one write port, one registered read port, heap-ordered nodes
// depends on mtfs_pkg
`default_nettype none

module mtfs_node_mem
    import mtfs_pkg::*;
(
    input  wire logic              aclk,
    input  wire mem_wr_t           wr,
    input  wire logic [NODE_W-1:0] rd_addr,
    output logic      [KEY_W-1:0]  rd_data
);

    logic [KEY_W-1:0] mem [0:NODE_CNT-1];
    logic [KEY_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/min_tree_floor_search_top.sv -----
// Min-tree floor search over up to 1024 slots of 64-bit keys, kept in heap order in one
// node memory. After reset and after every backing_size write the block sweeps the
// 2048-entry node memory to all-ones, one entry per cycle, and accepts no item
// meanwhile. A set writes the leaf, then refreshes the minima toward the root one
// tree level at a time (a set to a slot at or past the size is dropped); a find steps
// down one level at a time from the root, then loads the output register. Each level
// costs one read of the single node memory read port; one item is in work at a time.
// A finished find waits until the output register is free, then there until taken.
// depends on mtfs_pkg and mtfs_node_mem
`default_nettype none

module min_tree_floor_search_top
    import mtfs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input item stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [9:0] slot, [73:10] leaf_value, [74] leaf_occupied, [138:75] search_key
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  wire logic                 s_tuser,
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [9:0] found_index
    output logic      [M_TDATA_W-1:0] m_tdata,
    // backing_size write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_CLEAR     = 5'b00010,
        ST_SET_WALK  = 5'b00100,
        ST_FIND_WALK = 5'b01000,
        ST_FIND_DONE = 5'b10000
    } state_t;

    state_t              state_reg,  state_next;
    logic [SIZE_W-1:0]   size_reg,   size_next;
    logic [LVL_W-1:0]    lvl_reg,    lvl_next;
    logic [LVL_W-1:0]    cnt_reg,    cnt_next;
    logic [NODE_W-1:0]   node_reg,   node_next;
    logic [NODE_W-1:0]   clr_reg,    clr_next;
    logic [KEY_W-1:0]    cur_reg,    cur_next;
    logic [KEY_W-1:0]    key_reg,    key_next;
    logic                m_valid_reg, m_valid_next;
    logic [LEAF_W-1:0]   m_index_reg, m_index_next;

    mem_wr_t             mem_wr;
    logic [NODE_W-1:0]   mem_raddr;
    logic [KEY_W-1:0]    mem_rdata;

    // input field views
    logic [LEAF_W-1:0]   in_slot;
    logic [KEY_W-1:0]    in_leaf_value;
    logic                in_leaf_occupied;
    logic [KEY_W-1:0]    in_search_key;

    logic [NODE_W-1:0]   leaf_base;
    logic [NODE_W-1:0]   leaf_node;
    logic [NODE_W-1:0]   parent;
    logic [KEY_W-1:0]    walk_min;
    logic [NODE_W-1:0]   find_node;
    logic [NODE_W-1:0]   leaf_offset;
    logic [SIZE_W-1:0]   cfg_size;
    logic                in_xfer;
    logic                out_free;

    assign in_slot          = s_tdata[9:0];
    assign in_leaf_value    = s_tdata[73:10];
    assign in_leaf_occupied = s_tdata[74];
    assign in_search_key    = s_tdata[138:75];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-LEAF_W){1'b0}}, m_index_reg};

    // shared datapath: heap index arithmetic, one 64-bit minimum and one compare
    assign leaf_base   = NODE_W'(1) << lvl_reg;
    assign leaf_node   = leaf_base + {1'b0, in_slot};
    assign parent      = node_reg >> 1;
    assign walk_min    = (cur_reg < mem_rdata) ? cur_reg : mem_rdata;
    assign find_node   = (key_reg >= mem_rdata) ? {node_reg[NODE_W-2:0], 1'b1}
                                                : {node_reg[NODE_W-2:0], 1'b0};
    assign leaf_offset = node_reg - leaf_base;
    assign cfg_size    = clamp_size(cfg_data);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        size_next    = size_reg;
        lvl_next     = lvl_reg;
        cnt_next     = cnt_reg;
        node_next    = node_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        key_next     = key_reg;
        m_index_next = m_index_reg;
        m_valid_next = m_valid_reg && !m_tready;
        mem_wr.en    = 1'b0;
        mem_wr.addr  = node_reg;
        mem_wr.data  = cur_reg;
        mem_raddr    = node_reg ^ NODE_W'(1);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == CMD_SET) begin
                        if ({1'b0, in_slot} < size_reg) begin
                            mem_wr.en   = 1'b1;
                            mem_wr.addr = leaf_node;
                            mem_wr.data = in_leaf_occupied ? in_leaf_value : KEY_EMPTY;
                            mem_raddr   = leaf_node ^ NODE_W'(1);
                            node_next   = leaf_node;
                            cur_next    = mem_wr.data;
                            if (lvl_reg != '0) begin
                                state_next = ST_SET_WALK;
                            end
                        end
                    end else begin
                        node_next = NODE_W'(1);
                        key_next  = in_search_key;
                        cnt_next  = lvl_reg;
                        mem_raddr = NODE_W'(3);
                        if (lvl_reg == '0) begin
                            state_next = ST_FIND_DONE;
                        end else begin
                            state_next = ST_FIND_WALK;
                        end
                    end
                end
            end
            ST_CLEAR: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = clr_reg;
                mem_wr.data = KEY_EMPTY;
                clr_next    = clr_reg + NODE_W'(1);
                if (clr_reg == NODE_W'(NODE_CNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SET_WALK: begin
                // sibling is back: write the parent and fetch the parent's sibling
                mem_wr.en   = 1'b1;
                mem_wr.addr = parent;
                mem_wr.data = walk_min;
                mem_raddr   = parent ^ NODE_W'(1);
                cur_next    = walk_min;
                node_next   = parent;
                if (parent == NODE_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIND_WALK: begin
                // right child minimum is back: step down and fetch the next right child
                node_next = find_node;
                cnt_next  = cnt_reg - LVL_W'(1);
                mem_raddr = {find_node[NODE_W-2:0], 1'b1};
                if (cnt_reg == LVL_W'(1)) begin
                    state_next = ST_FIND_DONE;
                end
            end
            ST_FIND_DONE: begin
                if (out_free) begin
                    m_index_next = leaf_offset[LEAF_W-1:0];
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a size write restarts the clearing sweep
        if (cfg_valid && cfg_ready) begin
            size_next  = cfg_size;
            lvl_next   = levels_for_size(cfg_size);
            clr_next   = '0;
            state_next = ST_CLEAR;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            size_reg    <= SIZE_W'(LEAVES);
            lvl_reg     <= LVL_W'(MAX_LVL);
            cnt_reg     <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            lvl_reg     <= lvl_next;
            cnt_reg     <= cnt_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        node_reg    <= node_next;
        cur_reg     <= cur_next;
        key_reg     <= key_next;
        m_index_reg <= m_index_next;
    end

    mtfs_node_mem u_node_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench for min_tree_floor_search_top: set, find and size-write transfers, checked against a
// behavioral min-tree kept in a small scoreboard class; depends on mtfs_pkg and the RTL

module testbench;
    import mtfs_pkg::*;

    // behavioral min-tree plus the queue of found indexes still owed by the block
    class min_tree_tracker;
        logic [KEY_W-1:0]  node_min [NODE_CNT];
        int unsigned       slot_count;
        int unsigned       depth;
        logic [LEAF_W-1:0] expected_found [$];
        int unsigned       mismatches;

        function new();
            mismatches = 0;
            resize(SIZE_W'(LEAVES));
        endfunction

        // a size write clamps to 1..LEAVES and empties the whole tree
        function void resize(logic [SIZE_W-1:0] v);
            slot_count = (v == '0) ? 1 : ((v > LEAVES) ? LEAVES : v);
            depth = 0;
            while ((1 << depth) < slot_count) depth++;
            foreach (node_min[i]) node_min[i] = KEY_EMPTY;
        endfunction

        function void note_item(logic cmd, logic [LEAF_W-1:0] slot, logic [KEY_W-1:0] value,
                                logic occupied, logic [KEY_W-1:0] key);
            int unsigned      node;
            int unsigned      right;
            logic [KEY_W-1:0] lo;
            logic [KEY_W-1:0] hi;
            if (cmd == CMD_SET) begin
                // slots past the size already read as empty, nothing changes
                if (slot >= slot_count) return;
                node = (1 << depth) + slot;
                node_min[node] = occupied ? value : KEY_EMPTY;
                while (node > 1) begin
                    node = node >> 1;
                    lo = node_min[2 * node];
                    hi = node_min[2 * node + 1];
                    node_min[node] = (lo < hi) ? lo : hi;
                end
            end else begin
                // descend: right when the key reaches the right subtree's minimum
                node = 1;
                repeat (depth) begin
                    right = 2 * node + 1;
                    node = (key >= node_min[right]) ? right : 2 * node;
                end
                expected_found.push_back(LEAF_W'(node - (1 << depth)));
            end
        endfunction

        function void check_found(logic [M_TDATA_W-1:0] data);
            logic [LEAF_W-1:0] want;
            if (expected_found.size() == 0) begin
                $error("found_index expected none actual %0d", data[LEAF_W-1:0]);
                mismatches++;
            end else begin
                want = expected_found.pop_front();
                if (data[LEAF_W-1:0] !== want) begin
                    $error("found_index expected %0d actual %0d", want, data[LEAF_W-1:0]);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_found.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = CMD_SET;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SIZE_W-1:0]    cfg_data = '0;

    min_tree_tracker tracker;
    bit              send_burst = 1'b0;
    bit              recv_burst = 1'b0;

    min_tree_floor_search_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit, several times the slowest legal run
    initial begin
        #6_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // observe every transfer; all values sampled are the ones before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_found(m_tdata);
            // s_tdata: [9:0] slot, [73:10] leaf_value, [74] leaf_occupied,
            // [138:75] search_key
            if (s_tvalid && s_tready) begin
                tracker.note_item(s_tuser, s_tdata[9:0], s_tdata[73:10], s_tdata[74],
                                  s_tdata[138:75]);
            end
            if (cfg_valid && cfg_ready) tracker.resize(cfg_data);
        end
    end

    // result side: random stall before each transfer, with stretches of none
    initial begin
        int unsigned stall;
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0: k = '0;
            1: k = KEY_EMPTY;
            2: k = KEY_EMPTY - KEY_W'(1);
            3, 4, 5, 6: k = KEY_W'($urandom_range(0, 63));
            default: k = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    task automatic send_item(logic cmd, logic [LEAF_W-1:0] slot, logic [KEY_W-1:0] value,
                             logic occupied, logic [KEY_W-1:0] key);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, key, occupied, value, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic set_slot(int unsigned slot, logic [KEY_W-1:0] value, logic occupied);
        send_item(CMD_SET, LEAF_W'(slot), value, occupied, rand_key());
    endtask

    task automatic find_key(logic [KEY_W-1:0] key);
        send_item(CMD_FIND, LEAF_W'($urandom), rand_key(), 1'($urandom), key);
    endtask

    // hold the sender until every find is answered and the last set has settled
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly in-range sets and finds over a small key pool, some full-width noise
    task automatic random_item();
        int unsigned slot;
        if ($urandom_range(0, 6) == 0) begin
            slot = $urandom_range(0, LEAVES - 1);
        end else begin
            slot = $urandom_range(0, tracker.slot_count - 1);
        end
        if ($urandom_range(0, 1) == 0) begin
            set_slot(slot, rand_key(), $urandom_range(0, 4) != 0);
        end else begin
            find_key(rand_key());
        end
    endtask

    initial begin
        int unsigned sizes [13];
        int unsigned n;
        tracker = new();
        sizes = '{0, 1, 2, 3, 2047, 5, 17, 64, 100, 513, 1000, 1024, 0};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // empty tree at full size, then extremes of slot and key
        find_key('0);
        find_key(KEY_EMPTY);
        set_slot(0, '0, 1'b1);
        find_key('0);
        find_key(KEY_W'(5));
        set_slot(1023, KEY_W'(100), 1'b1);
        find_key(KEY_W'(99));
        find_key(KEY_W'(100));
        find_key(KEY_EMPTY);
        // an occupied all-ones key acts as an empty slot
        set_slot(512, KEY_EMPTY, 1'b1);
        find_key(KEY_EMPTY - KEY_W'(1));
        set_slot(1023, KEY_W'(100), 1'b0);
        find_key(KEY_W'(100));
        set_slot(511, KEY_EMPTY - KEY_W'(1), 1'b1);
        find_key(KEY_EMPTY - KEY_W'(1));
        find_key(KEY_EMPTY);

        for (int p = 0; p < 13; p++) begin
            if (p == 12) sizes[p] = $urandom_range(1, LEAVES);
            write_size(SIZE_W'(sizes[p]));
            // size zero reads as one slot: out-of-range sets are dropped
            if (p == 0) begin
                set_slot(0, KEY_W'(5), 1'b1);
                find_key(KEY_W'(4));
                find_key(KEY_W'(5));
                set_slot(1, '0, 1'b1);
                set_slot(1023, '0, 1'b1);
                find_key('0);
                find_key(KEY_EMPTY);
            end
            for (n = 0; n < 130; n++) begin
                if (n == 65 && p % 3 == 0) drain_results();
                random_item();
            end
        end

        drain_results();
        if (tracker.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mtfs_pkg.sv
rtl/mtfs_node_mem.sv
rtl/min_tree_floor_search_top.sv
dv/testbench.sv
